>>> sv/char_lcd_shadow_buffer_refresh_core_assert.svh
// Assertion macros used by the top-level RTL file of the character LCD shadow core.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef CHAR_LCD_SHADOW_BUFFER_REFRESH_CORE_ASSERT_SVH
`define CHAR_LCD_SHADOW_BUFFER_REFRESH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/clcd_pkg.sv
// Package for the character LCD shadow screen core: types, codes and constants.
// It has no dependencies and is used by the top-level RTL file.
package clcd_pkg;

    localparam int ROWS        = 16;
    localparam int COLUMNS     = 16;
    localparam int CELL_COUNT  = 256;
    localparam int CELL_AW     = 8;
    localparam int CHAR_W      = 8;
    localparam int CLEAR_CELLS = 32;
    localparam int LINE_CELLS  = 16;
    localparam int SCROLL_STEP = 32;
    localparam int SCROLL_WRAP = 240;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] LINE0_CMD  = 8'h80;
    localparam logic [7:0] LINE1_CMD  = 8'hC0;

    typedef enum logic [2:0] {
        MODE_SET_WRITE = 3'd0,
        MODE_PUT_ADV   = 3'd1,
        MODE_CLR_HOME  = 3'd2,
        MODE_CLEAR     = 3'd3,
        MODE_SCROLL_FW = 3'd4,
        MODE_SCROLL_BK = 3'd5,
        MODE_REFRESH   = 3'd6,
        MODE_SET_CUR   = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CMD,
        ST_READ,
        ST_DATA
    } state_t;

    function automatic logic [7:0] cell_reset(input logic [CELL_AW-1:0] addr);
        logic [7:0] ch;
        unique case (addr)
            8'd0:    ch = 8'h53;
            8'd1:    ch = 8'h54;
            8'd2:    ch = 8'h41;
            8'd3:    ch = 8'h52;
            8'd4:    ch = 8'h54;
            8'd253:  ch = 8'h45;
            8'd254:  ch = 8'h4E;
            8'd255:  ch = 8'h44;
            default: ch = SPACE_CHAR;
        endcase
        return ch;
    endfunction

endpackage

>>> sv/clcd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the shadow screen of the character LCD core.
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/char_lcd_shadow_buffer_refresh_core.sv
// Channel  | dir | tdata (low bit up)                   | tuser      | tlast
// s_axis   | in  | row[3:0] column[7:4] char_code[15:8] | mode[2:0]  | -
// m_axis   | out | lcd_byte[7:0]                        | is_data[0] | last
//
// Top level of the character LCD shadow screen core; uses clcd_pkg, clcd_ram
// and the assertion header.
// Cursor, put, scroll and set modes finish on acceptance. A clear writes spaces to
// the first 32 cells of the screen RAM, one write per cell. A refresh sends a line
// command and 16 data bytes per line for two lines; each data byte needs one RAM
// read and one load of the output register. Stalls on m_axis hold the sequence in
// place. Reset leaves the screen at its power-up text at once through per-cell valid bits.
`include "char_lcd_shadow_buffer_refresh_core_assert.svh"

module char_lcd_shadow_buffer_refresh_core #(
    parameter int ROWS = clcd_pkg::ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row[3:0], column[7:4], char_code[15:8]
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // lcd_byte[7:0]
    output logic [0:0]  m_axis_tuser,   // is_data[0]
    output logic        m_axis_tlast
);

    localparam int AW = clcd_pkg::CELL_AW;

    clcd_pkg::state_t state_reg, state_next;
    clcd_pkg::mode_t  mode;

    logic [3:0]    in_row, in_col, row_wrap;
    logic [7:0]    in_char;
    logic          in_acc;

    logic [3:0]    cur_row_reg, cur_row_next;
    logic [3:0]    cur_col_reg, cur_col_next;
    logic [AW-1:0] view_reg, view_next;
    logic [4:0]    cnt_reg, cnt_next;

    logic [8:0]    view_fw, view_bk;

    logic [clcd_pkg::CELL_COUNT-1:0] valid_reg;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_addr_reg;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata, cell_value;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_free, out_load;

    logic          is_cmd_byte, refresh_acc, st_cmd, st_read, st_data;

    assign mode    = clcd_pkg::mode_t'(s_axis_tuser);
    assign in_row  = s_axis_tdata[3:0];
    assign in_col  = s_axis_tdata[7:4];
    assign in_char = s_axis_tdata[15:8];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        row_wrap = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (in_row == 4'(k))
            begin
                row_wrap = 4'(k % ROWS);
            end
        end
    end

    always_comb
    begin
        view_fw = {1'b0, view_reg} + 9'(clcd_pkg::SCROLL_STEP);
        if (view_fw >= 9'(clcd_pkg::SCROLL_WRAP))
        begin
            view_fw = view_fw - 9'(clcd_pkg::SCROLL_WRAP);
        end
        view_bk = {1'b0, view_reg} + 9'(clcd_pkg::SCROLL_WRAP - clcd_pkg::SCROLL_STEP);
        if (view_bk >= 9'(clcd_pkg::SCROLL_WRAP))
        begin
            view_bk = view_bk - 9'(clcd_pkg::SCROLL_WRAP);
        end
    end

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign cell_value = rd_valid_reg ? ram_rdata : clcd_pkg::cell_reset(rd_addr_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clcd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode == clcd_pkg::MODE_CLR_HOME || mode == clcd_pkg::MODE_CLEAR)
                    begin
                        state_next = clcd_pkg::ST_CLEAR;
                    end
                    else if (mode == clcd_pkg::MODE_REFRESH)
                    begin
                        state_next = clcd_pkg::ST_CMD;
                    end
                end
            end
            clcd_pkg::ST_CLEAR:
            begin
                if (cnt_reg == 5'(clcd_pkg::CLEAR_CELLS - 1))
                begin
                    state_next = clcd_pkg::ST_IDLE;
                end
            end
            clcd_pkg::ST_CMD:
            begin
                if (out_free)
                begin
                    state_next = clcd_pkg::ST_READ;
                end
            end
            clcd_pkg::ST_READ:
            begin
                state_next = clcd_pkg::ST_DATA;
            end
            clcd_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    if (cnt_reg == 5'(2 * clcd_pkg::LINE_CELLS - 1))
                    begin
                        state_next = clcd_pkg::ST_IDLE;
                    end
                    else if (cnt_reg == 5'(clcd_pkg::LINE_CELLS - 1))
                    begin
                        state_next = clcd_pkg::ST_CMD;
                    end
                    else
                    begin
                        state_next = clcd_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = clcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        view_next     = view_reg;
        cnt_next      = cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = {cur_row_reg, cur_col_reg};
        ram_wdata     = in_char;
        ram_re        = 1'b0;
        ram_raddr     = view_reg + {3'b000, cnt_reg};
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            clcd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cnt_next      = '0;
                if (in_acc)
                begin
                    unique case (mode)
                        clcd_pkg::MODE_SET_WRITE:
                        begin
                            cur_row_next = row_wrap;
                            cur_col_next = in_col;
                            ram_we       = 1'b1;
                            ram_waddr    = {row_wrap, in_col};
                        end
                        clcd_pkg::MODE_PUT_ADV:
                        begin
                            ram_we       = 1'b1;
                            cur_col_next = cur_col_reg + 4'd1;
                        end
                        clcd_pkg::MODE_CLR_HOME:
                        begin
                            view_next = '0;
                        end
                        clcd_pkg::MODE_SCROLL_FW:
                        begin
                            view_next = view_fw[AW-1:0];
                        end
                        clcd_pkg::MODE_SCROLL_BK:
                        begin
                            view_next = view_bk[AW-1:0];
                        end
                        clcd_pkg::MODE_SET_CUR:
                        begin
                            cur_row_next = row_wrap;
                            cur_col_next = in_col;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            clcd_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {3'b000, cnt_reg};
                ram_wdata = clcd_pkg::SPACE_CHAR;
                cnt_next  = cnt_reg + 5'd1;
            end
            clcd_pkg::ST_CMD:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = cnt_reg[4] ? clcd_pkg::LINE1_CMD : clcd_pkg::LINE0_CMD;
                    out_data_next = 1'b0;
                    out_last_next = 1'b0;
                end
            end
            clcd_pkg::ST_READ:
            begin
                ram_re = 1'b1;
            end
            clcd_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = cell_value;
                    out_data_next = 1'b1;
                    out_last_next = (cnt_reg == 5'(2 * clcd_pkg::LINE_CELLS - 1));
                    cnt_next      = cnt_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clcd_pkg::ST_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            view_reg      <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            view_reg      <= view_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (ram_re)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
            rd_addr_reg  <= ram_raddr;
        end
    end

    clcd_ram #(
        .WIDTH (clcd_pkg::CHAR_W),
        .DEPTH (clcd_pkg::CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tuser[0] = out_data_reg;
    assign m_axis_tlast    = out_last_reg;

    assign is_cmd_byte = (m_axis_tdata == clcd_pkg::LINE0_CMD)
                      || (m_axis_tdata == clcd_pkg::LINE1_CMD);
    assign refresh_acc = in_acc && (mode == clcd_pkg::MODE_REFRESH);
    assign st_cmd      = (state_reg == clcd_pkg::ST_CMD);
    assign st_read     = (state_reg == clcd_pkg::ST_READ);
    assign st_data     = (state_reg == clcd_pkg::ST_DATA);

    `CLCD_ASSERT_SAME(a_last_is_data, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "last not data")
    `CLCD_ASSERT_SAME(a_cmd_code, m_axis_tvalid && !m_axis_tuser[0], is_cmd_byte, "bad command byte")
    `CLCD_ASSERT_NEXT(a_refresh_start, refresh_acc, st_cmd && cnt_reg == '0, "refresh start wrong")
    `CLCD_ASSERT_NEXT(a_no_write_in_refresh, st_read, st_data && $stable(view_reg), "no data stage")

endmodule
